@@ rtl/ppfl_pkg.sv @@
// Shared types and constants of the per-CPU page free-list allocator.
`default_nettype none

package ppfl_pkg;

    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 3;

    localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [1:0] STATUS_FREED     = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_REJECTED  = 2'd3;

    localparam logic [31:0] REGION_START_RESET = 32'h8000_0000;
    localparam logic [31:0] REGION_STOP_RESET  = 32'h8800_0000;

    typedef struct packed {
        logic accept;
        logic scan_next;
        logic steal_start;
        logic do_free;
        logic do_pop;
        logic set_empty;
        logic out_load;
    } ppfl_cmd_t;

    typedef struct packed {
        logic scan_valid;
        logic scan_own;
        logic scan_last;
        logic stealing;
        logic out_free;
    } ppfl_stat_t;

endpackage

`default_nettype wire

@@ rtl/ppfl_ctrl.sv @@
// Sequencing state machine of the page allocator: accept, check, scan, pop, push, deliver.
`default_nettype none

module ppfl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 in_free,
    output logic                 s_tready,
    input  ppfl_pkg::ppfl_stat_t stat,
    output ppfl_pkg::ppfl_cmd_t  cmd
);
    import ppfl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_HEAD  = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_ready;
    logic       hit;

    assign in_ready = aresetn && ((state_reg == S_IDLE) ||
                                  ((state_reg == S_OUT) && stat.out_free));
    assign s_tready = in_ready;
    assign hit      = stat.scan_valid && !(stat.stealing && stat.scan_own);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cmd.accept = s_tvalid && in_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = in_free ? S_CHECK : S_SCAN;
                end
            end
            S_CHECK: begin
                state_next = S_FREE;
            end
            S_FREE: begin
                cmd.do_free = 1'b1;
                state_next  = S_OUT;
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = S_HEAD;
                end else if (!stat.stealing) begin
                    cmd.steal_start = 1'b1;
                end else if (stat.scan_last) begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_HEAD: begin
                state_next = S_POP;
            end
            S_POP: begin
                cmd.do_pop = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (cmd.accept) begin
                        state_next = in_free ? S_CHECK : S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ppfl_dpath.sv @@
// Datapath of the page allocator: region registers, list heads, link memory, result beat.
`default_nettype none

module ppfl_dpath #(
    parameter int CPU_COUNT  = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppfl_pkg::ppfl_cmd_t                 cmd,
    output ppfl_pkg::ppfl_stat_t                stat,
    input  logic [ppfl_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_action,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppfl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [ppfl_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppfl_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata
);
    import ppfl_pkg::*;

    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PW = $clog2(NUM_PAGES);
    localparam int LB = $clog2(PAGE_BYTES);
    localparam int IW = 33 - LB;
    localparam logic [32:0] PAGE_MASK = 33'(PAGE_BYTES - 1);
    localparam logic [33:0] NUM_PAGES_W = 34'(NUM_PAGES);
    localparam logic [CW-1:0] LAST_CPU = CW'(CPU_COUNT - 1);

    function automatic logic [CW-1:0] cpu_wrap(input logic [2:0] c);
        logic [2:0] v;
        v = c;
        if (CPU_COUNT < 8) begin
            for (int i = 0; i < 8; i++) begin
                if (32'(v) >= CPU_COUNT) begin
                    v = v - 3'(CPU_COUNT);
                end
            end
        end
        return CW'(v);
    endfunction

    logic [31:0]     start_reg;
    logic [31:0]     stop_reg;
    logic [32:0]     base_reg;
    logic [CW-1:0]   cpu_reg;
    logic [CW-1:0]   scan_reg;
    logic [31:0]     addr_reg;
    logic            stealing_reg;
    logic [PW-1:0]   idx_reg;
    logic            check_ok_reg;
    logic [PW-1:0]   head_q;
    logic [PW:0]     link_q;
    logic [CPU_COUNT-1:0] head_valid_reg;
    logic [PW-1:0]   head_mem [CPU_COUNT];
    logic [PW:0]     link_mem [NUM_PAGES];
    logic [31:0]     res_addr_reg;
    logic [1:0]      res_status_reg;
    logic            res_stolen_reg;
    logic            m_valid_reg;
    logic [31:0]     m_addr_reg;
    logic [1:0]      m_status_reg;
    logic            m_stolen_reg;

    logic            cfg_write;
    logic [32:0]     diff;
    logic [IW-1:0]   idx_full;
    logic            check_ok;
    logic [31:0]     granted;
    logic            push;

    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[REG_SEL_BIT] ? stop_reg : start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= REGION_START_RESET;
            stop_reg  <= REGION_STOP_RESET;
        end else if (cfg_write) begin
            if (paddr[REG_SEL_BIT]) begin
                stop_reg <= pwdata;
            end else begin
                start_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= ({1'b0, start_reg} + PAGE_MASK) & ~PAGE_MASK;
    end

    assign diff     = {1'b0, addr_reg} - base_reg;
    assign idx_full = diff[32:LB];
    assign check_ok = ((33'(addr_reg) & PAGE_MASK) == 33'd0) &&
                      (addr_reg >= start_reg) &&
                      (addr_reg < stop_reg) &&
                      ({1'b0, addr_reg} >= base_reg) &&
                      (34'(idx_full) < NUM_PAGES_W);

    assign granted = base_reg[31:0] + (32'(head_q) << LB);
    assign push    = cmd.do_free && check_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg <= s_tdata[34:3];
            cpu_reg  <= cpu_wrap(s_tdata[2:0]);
        end
        check_ok_reg <= check_ok;
        idx_reg      <= PW'(idx_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg     <= '0;
            stealing_reg <= 1'b0;
        end else if (cmd.accept) begin
            scan_reg     <= cpu_wrap(s_tdata[2:0]);
            stealing_reg <= 1'b0;
        end else if (cmd.steal_start) begin
            scan_reg     <= '0;
            stealing_reg <= 1'b1;
        end else if (cmd.scan_next) begin
            scan_reg <= scan_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        head_q <= head_mem[scan_reg];
        if (push) begin
            head_mem[scan_reg] <= idx_reg;
        end else if (cmd.do_pop) begin
            head_mem[scan_reg] <= link_q[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        link_q <= link_mem[head_q];
        if (push) begin
            link_mem[idx_reg] <= {head_valid_reg[scan_reg], head_q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
        end else if (push) begin
            head_valid_reg[scan_reg] <= 1'b1;
        end else if (cmd.do_pop) begin
            head_valid_reg[scan_reg] <= link_q[PW];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_free) begin
            res_addr_reg   <= '0;
            res_status_reg <= check_ok_reg ? STATUS_FREED : STATUS_REJECTED;
            res_stolen_reg <= 1'b0;
        end else if (cmd.do_pop) begin
            res_addr_reg   <= granted;
            res_status_reg <= STATUS_ALLOCATED;
            res_stolen_reg <= stealing_reg;
        end else if (cmd.set_empty) begin
            res_addr_reg   <= '0;
            res_status_reg <= STATUS_EMPTY;
            res_stolen_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
            m_stolen_reg <= res_stolen_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = {m_stolen_reg, m_status_reg};

    assign stat.scan_valid = head_valid_reg[scan_reg];
    assign stat.scan_own   = (scan_reg == cpu_reg);
    assign stat.scan_last  = (scan_reg == LAST_CPU);
    assign stat.stealing   = stealing_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

    logic unused_action;
    assign unused_action = s_action & ^s_tdata[39:35];

endmodule

`default_nettype wire

@@ rtl/per_cpu_page_free_list_allocator.sv @@
// Top level of the per-CPU LIFO page allocator with stealing.
//
// Requests arrive as s_ beats: tuser[0] = action (0 allocate, 1 free), tdata holds
// cpu in [2:0] and the page byte address in [34:3]. Each request gives one m_ beat:
// tdata = granted address, tuser = status in [1:0] and the stolen flag in [2].
// region_start sits at APB offset 0 and region_stop at offset 4; write them only
// while no request is in flight.
// One request is in flight at a time. A free passes the address check, the push and
// the result load; an allocate served from the own list passes the scan, head read,
// link memory read and pop. When the own list is empty the scan visits the other
// lists in turn from CPU 0 to the last CPU and reports empty if none holds a page.
// The next request is accepted in the cycle its predecessor's result moves into
// the output register, so a new request is taken before that result beat is taken.
// Reset empties every list at once through per-CPU valid bits and restores the
// region registers; the link memory is not cleared. A stalled receiver holds the
// result beat in the output register, and the block then finishes the next
// request and waits with it until the output register drains.
`default_nettype none

module per_cpu_page_free_list_allocator #(
    parameter int CPU_COUNT  = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppfl_pkg::S_TDATA_W-1:0] s_tdata,   // cpu, page_address
    input  logic [0:0]                     s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppfl_pkg::M_TDATA_W-1:0] m_tdata,   // granted_address
    output logic [ppfl_pkg::M_TUSER_W-1:0] m_tuser,   // status, stolen
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppfl_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ppfl_pkg::*;

    ppfl_cmd_t  cmd;
    ppfl_stat_t stat;

    assign pready = 1'b1;

    ppfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_free  (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppfl_dpath #(
        .CPU_COUNT  (CPU_COUNT),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_action (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata)
    );

endmodule

`default_nettype wire

@@ tb/per_cpu_page_free_list_allocator_test.sv @@
// Self-checking testbench for the per-CPU page free-list allocator with stealing.
module per_cpu_page_free_list_allocator_test;
    import ppfl_pkg::*;

    localparam int CPU_COUNT      = 8;
    localparam int NUM_PAGES      = 32768;
    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = 12;
    localparam int PAGE_W         = 15;
    localparam int IDLE_PCT       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int N_DIRECTED     = 28;

    localparam logic [PADDR_W-1:0] REG_REGION_START = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] REG_REGION_STOP  = PADDR_W'(4);

    typedef enum logic {ACT_ALLOC = 1'b0, ACT_FREE = 1'b1} action_t;
    typedef enum logic {RK_REQ, RK_REGION} row_kind_t;
    typedef enum logic {CK_PRED, CK_TYPED} row_check_t;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
        logic        stolen;
    } grant_t;

    typedef struct {
        row_kind_t   kind;
        action_t     action;
        logic [2:0]  cpu;
        logic [31:0] address;      // region start on a region row
        logic [31:0] region_stop;
        row_check_t  check;
        grant_t      want;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;      // cpu, page_address
    logic [0:0]           s_tuser  = '0;      // action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // granted_address
    logic [M_TUSER_W-1:0] m_tuser;            // status, stolen
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    logic [31:0]     region_lo = REGION_START_RESET;
    logic [31:0]     region_hi = REGION_STOP_RESET;
    int              managed_pages = NUM_PAGES;
    bit [PAGE_W-1:0] link_page [NUM_PAGES];
    bit              link_valid [NUM_PAGES];
    int              list_refs [NUM_PAGES];
    bit [PAGE_W-1:0] head_page [CPU_COUNT];
    bit              head_valid [CPU_COUNT];

    grant_t pending_grants[$];
    int     failures = 0;
    bit     steady = 1'b0;
    int     holdoff_requests = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{RK_REQ, ACT_ALLOC, 3'd0, 32'h0000_0000, '0, CK_TYPED, '{'0, STATUS_EMPTY, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd0, 32'h8000_0000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd7, 32'h87FF_F000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd3, 32'h8800_0000, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd3, 32'h7FFF_F000, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd3, 32'h8000_0800, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd0, 32'h8000_1000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd0, 32'hFFFF_FFFF, '0, CK_TYPED,
          '{32'h8000_1000, STATUS_ALLOCATED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd0, 32'h0000_0000, '0, CK_TYPED,
          '{32'h8000_0000, STATUS_ALLOCATED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd0, 32'h0000_0000, '0, CK_TYPED,
          '{32'h87FF_F000, STATUS_ALLOCATED, 1'b1}},
        '{RK_REQ, ACT_ALLOC, 3'd5, 32'h0000_0000, '0, CK_TYPED, '{'0, STATUS_EMPTY, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd1, 32'h8000_5000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd4, 32'h8000_5000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd1, 32'h0000_0000, '0, CK_TYPED,
          '{32'h8000_5000, STATUS_ALLOCATED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd4, 32'h0000_0000, '0, CK_TYPED,
          '{32'h8000_5000, STATUS_ALLOCATED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd4, 32'h0000_0000, '0, CK_TYPED, '{'0, STATUS_EMPTY, 1'b0}},
        '{RK_REGION, ACT_ALLOC, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, CK_PRED, '0},
        '{RK_REQ, ACT_FREE, 3'd2, 32'h0800_0000, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd2, 32'h07FF_F000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd7, 32'hFFFF_FFFF, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_FREE, 3'd6, 32'h0000_0000, '0, CK_TYPED, '{'0, STATUS_FREED, 1'b0}},
        '{RK_REGION, ACT_ALLOC, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000, CK_PRED, '0},
        '{RK_REQ, ACT_FREE, 3'd6, 32'hFFFF_F000, '0, CK_TYPED, '{'0, STATUS_REJECTED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd6, 32'h0000_0000, '0, CK_TYPED,
          '{32'h0000_0000, STATUS_ALLOCATED, 1'b0}},
        '{RK_REQ, ACT_ALLOC, 3'd6, 32'h0000_0000, '0, CK_TYPED,
          '{32'h07FF_F000, STATUS_ALLOCATED, 1'b1}},
        '{RK_REGION, ACT_ALLOC, 3'd0, 32'h1234_5678, 32'h1240_0000, CK_PRED, '0},
        '{RK_REQ, ACT_FREE, 3'd5, 32'h1234_6000, '0, CK_PRED, '0},
        '{RK_REQ, ACT_ALLOC, 3'd3, 32'h0000_0000, '0, CK_PRED, '0}
    };

    per_cpu_page_free_list_allocator #(
        .CPU_COUNT  (CPU_COUNT),
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic logic [32:0] region_base();
        return ({1'b0, region_lo} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
    endfunction

    function automatic bit pop_page(int c, output bit [PAGE_W-1:0] page);
        page = head_page[c];
        if (!head_valid[c]) begin
            return 1'b0;
        end
        head_page[c]  = link_page[page];
        head_valid[c] = link_valid[page];
        list_refs[page]--;
        return 1'b1;
    endfunction

    function automatic grant_t predict_grant(action_t action, logic [2:0] cpu,
                                             logic [31:0] address);
        logic [32:0]     base;
        logic [32:0]     index;
        logic [32:0]     granted;
        bit [PAGE_W-1:0] page;
        bit              got;
        int              i;
        grant_t          g;
        base  = region_base();
        index = ({1'b0, address} - base) >> PAGE_SHIFT;
        g     = '{32'h0, STATUS_REJECTED, 1'b0};
        if (action == ACT_FREE) begin
            if (address[PAGE_SHIFT-1:0] == '0 && address >= region_lo && address < region_hi
                && {1'b0, address} >= base && index < 33'(NUM_PAGES)) begin
                link_page[index[PAGE_W-1:0]]  = head_page[cpu];
                link_valid[index[PAGE_W-1:0]] = head_valid[cpu];
                head_page[cpu]  = index[PAGE_W-1:0];
                head_valid[cpu] = 1'b1;
                list_refs[index[PAGE_W-1:0]]++;
                g.status = STATUS_FREED;
            end
        end else begin
            got = pop_page(cpu, page);
            for (i = 0; i < CPU_COUNT; i++) begin
                if (!got && i != cpu) begin
                    got      = pop_page(i, page);
                    g.stolen = got;
                end
            end
            if (got) begin
                granted   = base + (33'(page) << PAGE_SHIFT);
                g.address = granted[31:0];
                g.status  = STATUS_ALLOCATED;
            end else begin
                g.status = STATUS_EMPTY;
            end
        end
        return g;
    endfunction

    task automatic write_register(logic [PADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== value) begin
            $display("%0t: register %0d readback: expected %h, got %h",
                     $time, addr, value, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_region(logic [31:0] lo, logic [31:0] hi);
        logic [32:0] base;
        logic [32:0] span;
        write_register(REG_REGION_START, lo);
        write_register(REG_REGION_STOP, hi);
        region_lo = lo;
        region_hi = hi;
        base = region_base();
        span = ({1'b0, hi} > base)
             ? (({1'b0, hi} - base + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT)
             : 33'd0;
        managed_pages = (span > 33'(NUM_PAGES)) ? NUM_PAGES : int'(span);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic issue_request(action_t action, logic [2:0] cpu, logic [31:0] address,
                                 row_check_t check, grant_t typed);
        grant_t predicted;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({address, cpu});
        s_tuser  <= action;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_grant(action, cpu, address);
        pending_grants.push_back(check == CK_TYPED ? typed : predicted);
    endtask

    task automatic send_random_request(int alloc_pct);
        logic [2:0]  cpu;
        logic [31:0] address;
        logic [32:0] base;
        int          roll;
        int          idx;
        int          tries;
        bit          found;
        cpu     = 3'($urandom_range(0, CPU_COUNT - 1));
        address = $urandom();
        base    = region_base();
        roll    = $urandom_range(0, 99);
        found   = 1'b0;
        if (roll < alloc_pct) begin
            issue_request(ACT_ALLOC, cpu, address, CK_PRED, '0);
        end else begin
            if (roll < 95 && managed_pages > 0) begin
                for (tries = 0; tries < 8 && !found; tries++) begin
                    idx = $urandom_range(0, managed_pages - 1);
                    found = (list_refs[idx] == 0);
                end
                if (found) begin
                    address = 32'(base + (33'(idx) << PAGE_SHIFT));
                end
            end
            if (!found) begin
                // rejected addresses only: keep lists free of unintended repeats
                case ($urandom_range(0, 2))
                    0: begin
                        if (address[PAGE_SHIFT-1:0] == '0) address[0] = 1'b1;
                    end
                    1: address = region_hi;
                    default: address = region_lo - 32'd1;
                endcase
            end
            issue_request(ACT_FREE, cpu, address, CK_PRED, '0);
        end
    endtask

    initial begin
        grant_t want;
        int     hold_left;
        int     holdoffs_done;
        hold_left     = 0;
        holdoffs_done = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_grants.size() == 0) begin
                    $display("%0t: result beat with nothing pending: ",
                             "addr %h status %0d stolen %0d",
                             $time, m_tdata, m_tuser[1:0], m_tuser[2]);
                    failures++;
                end else begin
                    want = pending_grants.pop_front();
                    if (m_tdata !== want.address || m_tuser[1:0] !== want.status
                        || m_tuser[2] !== want.stolen) begin
                        $display("%0t: expected addr %h status %0d stolen %0d, ",
                                 "got addr %h status %0d stolen %0d",
                                 $time, want.address, want.status, want.stolen,
                                 m_tdata, m_tuser[1:0], m_tuser[2]);
                        failures++;
                    end
                end
            end
            if (holdoffs_done != holdoff_requests) begin
                holdoffs_done++;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          phase;
        int          n;
        int          items;
        int          alloc_pct;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [32:0] span;
        logic [2:0]  cpu;
        logic [31:0] address;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == RK_REGION) begin
                wait_drained();
                set_region(directed_rows[r].address, directed_rows[r].region_stop);
            end else begin
                issue_request(directed_rows[r].action, directed_rows[r].cpu,
                              directed_rows[r].address, directed_rows[r].check,
                              directed_rows[r].want);
            end
        end
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    lo = REGION_START_RESET;
                    hi = REGION_STOP_RESET;
                    items = 300;
                end
                1: begin
                    lo = 32'h0000_0000;
                    hi = 32'hFFFF_FFFF;
                    items = 200;
                end
                2: begin
                    lo   = $urandom();
                    span = {1'b0, lo} + 33'($urandom_range(16, 3000)) * PAGE_BYTES;
                    hi   = span[32] ? 32'hFFFF_FFFF : span[31:0];
                    items = 200;
                end
                3: begin
                    lo = 32'hFFFF_FFFF;
                    hi = 32'h0000_0000;
                    items = 80;
                end
                4: begin
                    lo = 32'hFFFF_0000;
                    hi = 32'hFFFF_FFFF;
                    items = 200;
                end
                default: begin
                    lo = REGION_START_RESET;
                    hi = REGION_STOP_RESET;
                    items = 100;
                end
            endcase
            wait_drained();
            set_region(lo, hi);
            alloc_pct = 50;
            for (n = 0; n < items; n++) begin
                if (n % 50 == 0) alloc_pct = 25 * $urandom_range(1, 3);
                steady = (phase == 0 && n >= 150);
                if (phase == 0 && n == 100) holdoff_requests++;
                if (phase == 1 && n == 100) wait_drained();
                send_random_request(alloc_pct);
            end
        end
        // free one page twice on the same cpu: the list turns cyclic
        cpu     = 3'($urandom_range(0, CPU_COUNT - 1));
        address = region_lo + 32'($urandom_range(0, 99)) * PAGE_BYTES;
        issue_request(ACT_FREE, cpu, address, CK_PRED, '0);
        issue_request(ACT_FREE, cpu, address, CK_PRED, '0);
        for (n = 0; n < 6; n++) begin
            issue_request(ACT_ALLOC, cpu, $urandom(), CK_PRED, '0);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ppfl_pkg.sv
rtl/ppfl_ctrl.sv
rtl/ppfl_dpath.sv
rtl/per_cpu_page_free_list_allocator.sv
tb/per_cpu_page_free_list_allocator_test.sv
